@@ rtl/knh_pkg.sv @@
// shared types and constants of the k-nearest max-heap selector
package knh_pkg;

  localparam int COORD_BITS = 20;
  localparam int ID_BITS = 20;
  localparam int DIST_BITS = 2 * COORD_BITS + 4;
  localparam int LIMIT_BITS = 7;
  localparam int DEF_MAX_NEIGHBORS = 64;
  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 7'd50;
  localparam logic [DIST_BITS-1:0] RADIUS_RESET = 44'd262144;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_OFFER = 2'd1,
    OP_DRAIN = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  localparam logic [1:0] REG_LIMIT = 2'd0;
  localparam logic [1:0] REG_RADIUS = 2'd1;

  typedef struct packed {
    logic [1:0] operation;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [COORD_BITS-1:0] point_z;
    logic [ID_BITS-1:0] point_id;
  } in_item_t;

  typedef struct packed {
    logic entry_valid;
    logic [DIST_BITS-1:0] entry_dist_sq;
    logic [ID_BITS-1:0] entry_id;
    logic [LIMIT_BITS-1:0] found_count;
    logic [DIST_BITS-1:0] bound_dist_sq;
    logic last;
  } out_item_t;

  typedef struct packed {
    logic start_query;
    logic offer_latch;
    logic dist_run;
    logic append;
    logic heap_init;
    logic load_read;
    logic load_latch;
    logic child_read;
    logic child_step;
    logic fin_write;
    logic k_dec;
    logic repl_init;
    logic root_read;
    logic bound_load;
    logic drain_init;
    logic drain_read;
    logic drain_emit;
    logic empty_emit;
  } cmd_t;

  typedef struct packed {
    logic dist_done;
    logic d_lt_bound;
    logic count_lt_k;
    logic count_zero;
    logic heap_ready;
    logic half_zero;
    logic c_le_n;
    logic brk;
    logic strict;
    logic k_is_one;
    logic drain_last;
  } status_t;

endpackage

@@ rtl/knh_ram.sv @@
// generic single-write dual-read ram with registered read data
module knh_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

@@ rtl/knh_ctrl.sv @@
// controller state machine of the k-nearest selector
module knh_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [1:0]       operation,
  input  knh_pkg::status_t status,
  output knh_pkg::cmd_t    cmd,
  output logic             busy
);
  import knh_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_DIST   = 12'b000000000010,
    S_CHECK  = 12'b000000000100,
    S_HLOAD  = 12'b000000001000,
    S_HLATCH = 12'b000000010000,
    S_SREAD  = 12'b000000100000,
    S_SCMP   = 12'b000001000000,
    S_SFIN   = 12'b000010000000,
    S_ROOT   = 12'b000100000000,
    S_BOUND  = 12'b001000000000,
    S_DREAD  = 12'b010000000000,
    S_DEMIT  = 12'b100000000000
  } state_t;

  state_t state, state_next;
  logic accept;

  assign busy = (state != S_IDLE);
  assign accept = start && (state == S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (op_t'(operation))
            OP_START: cmd.start_query = 1'b1;
            OP_OFFER: begin
              cmd.offer_latch = 1'b1;
              state_next = S_DIST;
            end
            OP_DRAIN: begin
              if (status.count_zero) begin
                cmd.empty_emit = 1'b1;
              end else begin
                cmd.drain_init = 1'b1;
                state_next = S_DREAD;
              end
            end
            default: ;
          endcase
        end
      end
      S_DIST: begin
        cmd.dist_run = 1'b1;
        if (status.dist_done) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (!status.d_lt_bound) begin
          state_next = S_IDLE;
        end else if (status.count_lt_k) begin
          cmd.append = 1'b1;
          state_next = S_IDLE;
        end else if (status.heap_ready || status.half_zero) begin
          cmd.repl_init = 1'b1;
          state_next = S_SREAD;
        end else begin
          cmd.heap_init = 1'b1;
          state_next = S_HLOAD;
        end
      end
      S_HLOAD: begin
        cmd.load_read = 1'b1;
        state_next = S_HLATCH;
      end
      S_HLATCH: begin
        cmd.load_latch = 1'b1;
        state_next = S_SREAD;
      end
      S_SREAD: begin
        cmd.child_read = 1'b1;
        state_next = status.c_le_n ? S_SCMP : S_SFIN;
      end
      S_SCMP: begin
        if (status.brk) begin
          state_next = S_SFIN;
        end else begin
          cmd.child_step = 1'b1;
          state_next = S_SREAD;
        end
      end
      S_SFIN: begin
        cmd.fin_write = 1'b1;
        if (status.strict) begin
          state_next = S_ROOT;
        end else if (status.k_is_one) begin
          cmd.repl_init = 1'b1;
          state_next = S_SREAD;
        end else begin
          cmd.k_dec = 1'b1;
          state_next = S_HLOAD;
        end
      end
      S_ROOT: begin
        cmd.root_read = 1'b1;
        state_next = S_BOUND;
      end
      S_BOUND: begin
        cmd.bound_load = 1'b1;
        state_next = S_IDLE;
      end
      S_DREAD: begin
        cmd.drain_read = 1'b1;
        state_next = S_DEMIT;
      end
      S_DEMIT: begin
        cmd.drain_emit = 1'b1;
        state_next = status.drain_last ? S_IDLE : S_DREAD;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ rtl/knh_dp.sv @@
// datapath: distance unit, held-entry ram, sift registers and result register
module knh_dp #(
  parameter int MAX_NEIGHBORS = knh_pkg::DEF_MAX_NEIGHBORS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  knh_pkg::in_item_t                   item,
  input  knh_pkg::cmd_t                       cmd,
  output knh_pkg::status_t                    status,
  input  logic                                cfg_we,
  input  logic [1:0]                          cfg_index,
  input  logic [knh_pkg::DIST_BITS-1:0]       cfg_data,
  output knh_pkg::out_item_t                  result,
  output logic                                result_valid
);
  import knh_pkg::*;

  localparam int AW = $clog2(MAX_NEIGHBORS);
  localparam int CW = $clog2(MAX_NEIGHBORS + 1);
  localparam int SW = CW + 1;
  localparam int EW = DIST_BITS + ID_BITS;
  localparam int DW = COORD_BITS + 1;

  logic [LIMIT_BITS-1:0] neighbor_limit;
  logic [DIST_BITS-1:0]  radius_sq_limit;
  logic signed [COORD_BITS-1:0] query_x, query_y, query_z;
  logic signed [COORD_BITS-1:0] pt_x, pt_y, pt_z;
  logic [ID_BITS-1:0]   pt_id;
  logic [DIST_BITS-1:0] bound_sq;
  logic [CW-1:0]        held_count;
  logic                 heap_ready;
  logic [1:0]           dist_cnt;
  logic [2*DW-1:0]      prod;
  logic [DIST_BITS-1:0] acc;
  logic [DIST_BITS-1:0] dv;
  logic [ID_BITS-1:0]   iv;
  logic                 strict;
  logic [SW-1:0]        par;
  logic [CW-1:0]        kidx;
  logic [CW-1:0]        didx;

  logic [CW-1:0]        k_eff;
  logic signed [DW-1:0] diff;
  logic signed [2*DW-1:0] sq;
  logic [SW-1:0]        cidx, cpick;
  logic [EW-1:0]        rdata_a, rdata_b, child;
  logic                 use_b;
  logic                 we;
  logic [AW-1:0]        waddr, raddr_a, raddr_b;
  logic [EW-1:0]        wdata;

  // effective k, clamped to one..depth
  always_comb begin
    if (neighbor_limit == '0) begin
      k_eff = CW'(1);
    end else if (32'(neighbor_limit) > MAX_NEIGHBORS) begin
      k_eff = CW'(MAX_NEIGHBORS);
    end else begin
      k_eff = CW'(neighbor_limit);
    end
  end

  always_comb begin
    case (dist_cnt)
      2'd0:    diff = DW'(pt_x) - DW'(query_x);
      2'd1:    diff = DW'(pt_y) - DW'(query_y);
      default: diff = DW'(pt_z) - DW'(query_z);
    endcase
    sq = diff * diff;
  end

  // heap children of the current parent slot
  assign cidx = par << 1;
  assign use_b = (cidx < SW'(held_count)) &&
                 (rdata_a[EW-1 -: DIST_BITS] < rdata_b[EW-1 -: DIST_BITS]);
  assign child = use_b ? rdata_b : rdata_a;
  assign cpick = use_b ? cidx + SW'(1) : cidx;

  always_comb begin
    if (cmd.drain_read) begin
      raddr_a = AW'(didx);
    end else if (cmd.load_read) begin
      raddr_a = AW'(kidx - CW'(1));
    end else if (cmd.root_read) begin
      raddr_a = '0;
    end else begin
      raddr_a = AW'(cidx - SW'(1));
    end
    raddr_b = AW'(cidx);
  end

  always_comb begin
    we = cmd.append || cmd.child_step || cmd.fin_write;
    if (cmd.append) begin
      waddr = AW'(held_count);
      wdata = {acc, pt_id};
    end else if (cmd.child_step) begin
      waddr = AW'(par - SW'(1));
      wdata = child;
    end else begin
      waddr = AW'(par - SW'(1));
      wdata = {dv, iv};
    end
  end

  knh_ram #(.WIDTH(EW), .DEPTH(MAX_NEIGHBORS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr_a(raddr_a), .rdata_a(rdata_a), .raddr_b(raddr_b), .rdata_b(rdata_b)
  );

  always_comb begin
    status.dist_done  = (dist_cnt == 2'd3);
    status.d_lt_bound = (acc < bound_sq);
    status.count_lt_k = (held_count < k_eff);
    status.count_zero = (held_count == '0);
    status.heap_ready = heap_ready;
    status.half_zero  = ((held_count >> 1) == '0);
    status.c_le_n     = (cidx <= SW'(held_count));
    status.brk        = strict ? (dv > child[EW-1 -: DIST_BITS])
                               : (dv >= child[EW-1 -: DIST_BITS]);
    status.strict     = strict;
    status.k_is_one   = (kidx == CW'(1));
    status.drain_last = (didx + CW'(1) == held_count);
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      neighbor_limit  <= LIMIT_RESET;
      radius_sq_limit <= RADIUS_RESET;
      query_x    <= '0;
      query_y    <= '0;
      query_z    <= '0;
      bound_sq   <= RADIUS_RESET;
      held_count <= '0;
      heap_ready <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.drain_emit || cmd.empty_emit;
      if (cfg_we && cfg_index == REG_LIMIT) neighbor_limit <= cfg_data[LIMIT_BITS-1:0];
      if (cfg_we && cfg_index == REG_RADIUS) radius_sq_limit <= cfg_data;
      if (cmd.start_query) begin
        query_x    <= item.point_x;
        query_y    <= item.point_y;
        query_z    <= item.point_z;
        held_count <= '0;
        heap_ready <= 1'b0;
        bound_sq   <= radius_sq_limit;
      end
      if (cmd.append) begin
        held_count <= held_count + CW'(1);
        heap_ready <= 1'b0;
      end
      if (cmd.repl_init) heap_ready <= 1'b1;
      if (cmd.bound_load) bound_sq <= rdata_a[EW-1 -: DIST_BITS];
    end
  end

  // payload and sift registers
  always_ff @(posedge clk) begin
    if (cmd.offer_latch) begin
      pt_x <= item.point_x;
      pt_y <= item.point_y;
      pt_z <= item.point_z;
      pt_id <= item.point_id;
      dist_cnt <= 2'd0;
    end
    if (cmd.dist_run) begin
      dist_cnt <= dist_cnt + 2'd1;
      prod <= sq;
      if (dist_cnt == 2'd1) begin
        acc <= DIST_BITS'(prod);
      end else if (dist_cnt != 2'd0) begin
        acc <= acc + DIST_BITS'(prod);
      end
    end
    if (cmd.heap_init) kidx <= held_count >> 1;
    if (cmd.k_dec) kidx <= kidx - CW'(1);
    if (cmd.load_latch) begin
      dv <= rdata_a[EW-1 -: DIST_BITS];
      iv <= rdata_a[ID_BITS-1:0];
      par <= SW'(kidx);
      strict <= 1'b0;
    end
    if (cmd.repl_init) begin
      dv <= acc;
      iv <= pt_id;
      par <= SW'(1);
      strict <= 1'b1;
    end
    if (cmd.child_step) par <= cpick;
    if (cmd.drain_init) didx <= '0;
    if (cmd.drain_emit) begin
      didx <= didx + CW'(1);
      result.entry_valid   <= 1'b1;
      result.entry_dist_sq <= rdata_a[EW-1 -: DIST_BITS];
      result.entry_id      <= rdata_a[ID_BITS-1:0];
      result.found_count   <= LIMIT_BITS'(held_count);
      result.bound_dist_sq <= bound_sq;
      result.last          <= status.drain_last;
    end
    if (cmd.empty_emit) begin
      result.entry_valid   <= 1'b0;
      result.entry_dist_sq <= '0;
      result.entry_id      <= '0;
      result.found_count   <= '0;
      result.bound_dist_sq <= bound_sq;
      result.last          <= 1'b1;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    32'(held_count) <= MAX_NEIGHBORS) else $error("held count beyond depth");
  a_emit_beat: assert property (@(posedge clk) disable iff (rst)
    (cmd.drain_emit || cmd.empty_emit) |=> result_valid) else $error("lost result beat");
  a_slot_nonzero: assert property (@(posedge clk) disable iff (rst)
    (cmd.child_step || cmd.fin_write) |-> (par != '0)) else $error("write to slot zero");

endmodule

@@ rtl/k_nearest_max_heap_select_core.sv @@
// top level of the k-nearest max-heap selector
// usage:
//   items enter on start/item and are taken when start is high and busy low.
//   a start item latches the query point and reloads the bound.
//   an offer runs the shared 21x21 multiplier over the three axes to form the
//   squared distance, compares it with the bound, and on a hit either appends
//   or sifts down the heap: each level is a dual ram read, then compare and
//   move, followed by a closing read, the final write, a root read and the
//   bound load. the first full hit after any append also heapifies, loading
//   each parent slot and sinking it level by level.
//   a drain gives one result beat per held entry (ram read, then capture),
//   last marked on the final beat; an empty drain gives a single beat in the
//   cycle after acceptance.
//   results are shown for exactly one cycle with result_valid; the receiver
//   cannot stall them. configuration writes (cfg_valid, always ready) are taken
//   in any cycle and must only be issued while the block is idle.
//   reset clears the query, count and heap flag and loads register defaults;
//   held entries are undefined until appended.
module k_nearest_max_heap_select_core #(
  parameter int MAX_NEIGHBORS = knh_pkg::DEF_MAX_NEIGHBORS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  knh_pkg::in_item_t             item,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [knh_pkg::DIST_BITS-1:0] cfg_data,
  output knh_pkg::out_item_t            result,
  output logic                          result_valid
);
  import knh_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  knh_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .operation(item.operation),
    .status(status), .cmd(cmd), .busy(busy)
  );

  knh_dp #(.MAX_NEIGHBORS(MAX_NEIGHBORS)) u_dp (
    .clk(clk), .rst(rst), .item(item), .cmd(cmd), .status(status),
    .cfg_we(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .result(result), .result_valid(result_valid)
  );

endmodule

@@ tb/tb.sv @@
// testbench for the k-nearest max-heap selector: directed and random queries checked
// against a behavioural predictor
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import knh_pkg::*;

  class heap_scoreboard;
    logic [6:0] limit_reg;
    logic [DIST_BITS-1:0] radius_reg;
    logic signed [COORD_BITS-1:0] qx, qy, qz;
    logic [DIST_BITS-1:0] bound;
    logic [DIST_BITS-1:0] dist_slot [1:64];
    logic [ID_BITS-1:0] id_slot [1:64];
    int unsigned held;
    bit heaped;
    out_item_t pending [$];
    int errors;

    function new();
      limit_reg = LIMIT_RESET;
      radius_reg = RADIUS_RESET;
      qx = '0; qy = '0; qz = '0;
      bound = RADIUS_RESET;
      held = 0;
      heaped = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [DIST_BITS-1:0] data);
      if (idx == REG_LIMIT) limit_reg = data[6:0];
      else if (idx == REG_RADIUS) radius_reg = data;
    endfunction

    function logic [DIST_BITS-1:0] dist_to_query(in_item_t it);
      longint dx, dy, dz;
      dx = longint'(it.point_x) - longint'(qx);
      dy = longint'(it.point_y) - longint'(qy);
      dz = longint'(it.point_z) - longint'(qz);
      return DIST_BITS'(dx * dx + dy * dy + dz * dz);
    endfunction

    function void heapify(int unsigned n);
      int unsigned half, k, par, c;
      logic [DIST_BITS-1:0] dv;
      logic [ID_BITS-1:0] iv;
      half = n >> 1;
      for (k = half; k >= 1; k--) begin
        par = k;
        dv = dist_slot[k];
        iv = id_slot[k];
        while (par <= half) begin
          c = 2 * par;
          if (c < n && dist_slot[c] < dist_slot[c + 1]) c++;
          if (dv >= dist_slot[c]) break;
          dist_slot[par] = dist_slot[c];
          id_slot[par] = id_slot[c];
          par = c;
        end
        dist_slot[par] = dv;
        id_slot[par] = iv;
      end
    endfunction

    function void sift_root(int unsigned n, logic [DIST_BITS-1:0] dv, logic [ID_BITS-1:0] iv);
      int unsigned par, c;
      par = 1;
      c = 2;
      while (c <= n) begin
        if (c < n && dist_slot[c] < dist_slot[c + 1]) c++;
        if (dv > dist_slot[c]) break;
        dist_slot[par] = dist_slot[c];
        id_slot[par] = id_slot[c];
        par = c;
        c = 2 * c;
      end
      dist_slot[par] = dv;
      id_slot[par] = iv;
      bound = dist_slot[1];
    endfunction

    function void note_item(in_item_t it);
      logic [DIST_BITS-1:0] d;
      int unsigned k;
      out_item_t r;
      case (op_t'(it.operation))
        OP_START: begin
          qx = it.point_x; qy = it.point_y; qz = it.point_z;
          held = 0;
          heaped = 0;
          bound = radius_reg;
        end
        OP_OFFER: begin
          d = dist_to_query(it);
          k = (limit_reg == 0) ? 1 : (limit_reg > 64 ? 64 : limit_reg);
          if (d < bound) begin
            if (held < k) begin
              held++;
              dist_slot[held] = d;
              id_slot[held] = it.point_id;
              heaped = 0;
            end else begin
              if (!heaped) begin
                heapify(held);
                heaped = 1;
              end
              sift_root(held, d, it.point_id);
            end
          end
        end
        OP_DRAIN: begin
          if (held == 0) begin
            r = '0;
            r.bound_dist_sq = bound;
            r.last = 1'b1;
            pending = {pending, r};
          end else begin
            for (int i = 1; i <= held; i++) begin
              r.entry_valid = 1'b1;
              r.entry_dist_sq = dist_slot[i];
              r.entry_id = id_slot[i];
              r.found_count = 7'(held);
              r.bound_dist_sq = bound;
              r.last = (i == held);
              pending = {pending, r};
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_beat(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p actual %p", want, got);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  in_item_t item = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [DIST_BITS-1:0] cfg_data = '0;
  out_item_t result;
  logic result_valid;

  heap_scoreboard board = new();
  int idle_cycles = 0;

  always #10 clk = ~clk;

  k_nearest_max_heap_select_core dut (.*);

  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid) board.check_beat(result);
      if ((start && !busy) || (cfg_valid && cfg_ready) || result_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  // start stays high into the next beat when there is no gap
  task automatic send_item(in_item_t it);
    int unsigned gap;
    gap = $urandom_range(0, 16);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item <= it;
    do @(posedge clk); while (busy);
    board.note_item(it);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [DIST_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // wait for all expected beats, then let a full replacement finish
  task automatic settle();
    start <= 1'b0;
    while (board.pending.size() != 0 || busy) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic in_item_t make_item(op_t op, int span);
    in_item_t it;
    it.operation = op;
    it.point_x = COORD_BITS'($urandom_range(0, 2 * span) - span);
    it.point_y = COORD_BITS'($urandom_range(0, 2 * span) - span);
    it.point_z = COORD_BITS'($urandom_range(0, 2 * span) - span);
    it.point_id = ID_BITS'($urandom);
    return it;
  endfunction

  task automatic run_query(int offers, int span);
    send_item(make_item(OP_START, span));
    for (int i = 0; i < offers; i++) begin
      send_item(make_item(OP_OFFER, span));
      if ($urandom_range(0, 15) == 0) send_item(make_item(OP_DRAIN, span));
    end
    send_item(make_item(OP_DRAIN, span));
  endtask

  initial begin
    in_item_t it;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty drain, an offer before any start, extremes, unused code
    send_item(make_item(OP_DRAIN, 100));
    send_item(make_item(OP_OFFER, 300));
    send_item(make_item(OP_DRAIN, 100));
    settle();
    write_cfg(REG_RADIUS, {DIST_BITS{1'b1}});
    write_cfg(REG_LIMIT, 44'd2);
    it = '0; it.operation = OP_START; it.point_x = 20'sh80000;
    it.point_y = 20'sh80000; it.point_z = 20'sh80000;
    send_item(it);
    it.operation = OP_OFFER; it.point_x = 20'sh7ffff; it.point_y = 20'sh7ffff;
    it.point_z = 20'sh7ffff; it.point_id = 20'hfffff;
    send_item(it);
    it.point_id = 20'h0; it.point_x = 20'sh0;
    send_item(it);
    it.point_id = 20'h12345; it.point_y = 20'sh0;
    send_item(it);
    it.point_id = 20'h5a5a5; it.point_z = 20'sh0;
    send_item(it);
    it.operation = OP_NONE;
    send_item(it);
    send_item(make_item(OP_DRAIN, 1));
    send_item(make_item(OP_DRAIN, 1));
    settle();

    // limit 0 acts as one, radius 0 rejects everything
    write_cfg(REG_LIMIT, 44'd0);
    run_query(5, 1000);
    settle();
    write_cfg(REG_RADIUS, '0);
    run_query(3, 1000);
    settle();
    write_cfg(REG_LIMIT, 44'd127);
    write_cfg(REG_RADIUS, 44'd4000000);
    run_query(20, 1000);
    settle();

    // random phases through several settings
    for (int ph = 0; ph < 8; ph++) begin
      write_cfg(REG_LIMIT, DIST_BITS'((ph == 3) ? 64 : $urandom_range(1, 12)));
      write_cfg(REG_RADIUS, (ph == 5) ? {DIST_BITS{1'b1}} :
                44'($urandom_range(1000, 3000000)));
      for (int q = 0; q < 2; q++) begin
        run_query((ph == 3 && q == 0) ? 60 : $urandom_range(3, 12), 1000);
        if ($urandom_range(0, 3) == 0) send_item(make_item(op_t'($urandom_range(0, 3)), 524287));
      end
      // change K in the middle of a query
      if (ph == 6) begin
        send_item(make_item(OP_START, 500));
        repeat (8) send_item(make_item(OP_OFFER, 500));
        settle();
        write_cfg(REG_LIMIT, 44'd3);
        repeat (4) send_item(make_item(OP_OFFER, 500));
        send_item(make_item(OP_DRAIN, 500));
      end
      settle();
    end

    settle();
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end
endmodule
